// File: rtl/rqs_pkg.sv
// Package for the ready queue scheduler: table depth, index widths, item
// and table entry structs, function, mode, status and register codes.
// No dependencies.
`default_nettype none

package rqs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd1;

    localparam logic [1:0] FN_INSERT  = 2'd0;
    localparam logic [1:0] FN_SELECT  = 2'd1;
    localparam logic [1:0] FN_SETWAIT = 2'd2;

    localparam logic [1:0] MD_FIFO = 2'd0;
    localparam logic [1:0] MD_SJF  = 2'd1;
    localparam logic [1:0] MD_HRRN = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] WR_INSERT = 2'd0;
    localparam logic [1:0] WR_WAIT   = 2'd1;
    localparam logic [1:0] WR_MOVE   = 2'd2;

    localparam logic [8:0] ALPHA_ONE   = 9'd256;
    localparam logic [8:0] ALPHA_RESET = 9'd128;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] proc_id;
        logic [23:0] prev_estimate;
        logic [15:0] last_burst;
        logic [15:0] waited;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen_id;
        logic [23:0] chosen_estimate;
        logic [4:0]  ready_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [23:0] prev_estimate;
        logic [15:0] burst;
        logic [15:0] waited;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic       cap_item;
        logic       ram_re;
        logic       rd_next;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_best;
        logic       est1_en;
        logic       est2_en;
        logic       xp_en;
        logic       cmp_en;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       empty;
        logic       more;
        logic       id_match;
        logic       out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/rqs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module rqs_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/rqs_dp.sv
// Datapath of the ready queue scheduler: config registers, item register,
// table RAM, estimate and ratio arithmetic, best tracking, result register.
// Depends on rqs_pkg and rqs_ram.
`default_nettype none

module rqs_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rqs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rqs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire rqs_pkg::t_in_item              i_item,
    output rqs_pkg::t_out_item                  o_result,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    input  wire rqs_pkg::t_dp_cmd               i_cmd,
    output rqs_pkg::t_dp_stat                   o_stat
);

    localparam int CW = rqs_pkg::CNT_W;
    localparam int IW = rqs_pkg::IDX_W;

    logic [1:0]              r_mode;
    logic [8:0]              r_alpha;
    rqs_pkg::t_in_item       r_item;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic [IW-1:0]           r_best_idx;
    logic [15:0]             r_best_id;
    logic [23:0]             r_best_est;
    logic [15:0]             r_best_w;
    logic [15:0]             r_cand_id;
    logic [15:0]             r_cand_w;
    logic [23:0]             r_cand_est;
    logic [32:0]             r_pa;
    logic [24:0]             r_pb;
    logic [39:0]             r_p1;
    logic [39:0]             r_p2;
    rqs_pkg::t_out_item      r_out;
    logic                    r_out_valid;

    rqs_pkg::t_entry         rdata;
    rqs_pkg::t_entry         wdata;
    logic [IW-1:0]           waddr;
    logic [IW-1:0]           raddr;
    logic [CW-1:0]           idx_next;
    logic [8:0]              a_sat;
    logic [8:0]              a_rest;
    logic [33:0]             est_sum;
    logic                    better;
    logic                    take;

    assign idx_next = r_idx + CW'(1);
    assign a_sat    = (r_alpha > rqs_pkg::ALPHA_ONE) ? rqs_pkg::ALPHA_ONE : r_alpha;
    assign a_rest   = rqs_pkg::ALPHA_ONE - a_sat;
    assign est_sum  = 34'(r_pa) + {1'b0, r_pb, 8'b0};

    always_comb begin
        wdata = rdata;
        waddr = r_idx[IW-1:0];
        case (i_cmd.wr_sel)
            rqs_pkg::WR_INSERT: begin
                wdata.id            = r_item.proc_id;
                wdata.prev_estimate = r_item.prev_estimate;
                wdata.burst         = r_item.last_burst;
                wdata.waited        = r_item.waited;
                waddr               = r_count[IW-1:0];
            end
            rqs_pkg::WR_WAIT: begin
                wdata.waited = r_item.waited;
            end
            default: begin
            end
        endcase
    end

    assign raddr = i_cmd.rd_next ? idx_next[IW-1:0] : r_idx[IW-1:0];

    rqs_ram #(
        .WIDTH (rqs_pkg::ENTRY_W),
        .DEPTH (rqs_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        better = 1'b0;
        case (r_mode)
            rqs_pkg::MD_SJF: begin
                better = r_cand_est < r_best_est;
            end
            rqs_pkg::MD_HRRN: begin
                if (r_best_est == '0) begin
                    better = 1'b0;
                end else if (r_cand_est == '0) begin
                    better = 1'b1;
                end else begin
                    better = r_p1 > r_p2;
                end
            end
            default: begin
                better = 1'b0;
            end
        endcase
    end

    assign take = (r_idx == '0) || better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= rqs_pkg::MD_FIFO;
            r_alpha     <= rqs_pkg::ALPHA_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rqs_pkg::CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                    rqs_pkg::CFG_ALPHA: r_alpha <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_next;
            end else if (i_cmd.idx_best) begin
                r_idx <= take ? r_idx : CW'(r_best_idx);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_item <= i_item;
        end
        if (i_cmd.est1_en) begin
            r_cand_id <= rdata.id;
            r_cand_w  <= rdata.waited;
            r_pa      <= 33'(a_sat) * 33'(rdata.prev_estimate);
            r_pb      <= 25'(a_rest) * 25'(rdata.burst);
        end
        if (i_cmd.est2_en) begin
            r_cand_est <= est_sum[31:8];
        end
        if (i_cmd.xp_en) begin
            r_p1 <= 40'(r_cand_w) * 40'(r_best_est);
            r_p2 <= 40'(r_best_w) * 40'(r_cand_est);
        end
        if (i_cmd.cmp_en && take) begin
            r_best_idx <= r_idx[IW-1:0];
            r_best_id  <= r_cand_id;
            r_best_est <= r_cand_est;
            r_best_w   <= r_cand_w;
        end
        if (i_cmd.res_load) begin
            r_out.status          <= i_cmd.res_status;
            r_out.chosen_id       <= i_cmd.res_sel ? r_best_id : '0;
            r_out.chosen_estimate <= i_cmd.res_sel ? r_best_est : '0;
            r_out.ready_count     <= 5'(r_count);
        end
    end

    assign o_result        = r_out;
    assign o_valid         = r_out_valid;

    assign o_stat.func     = r_item.func;
    assign o_stat.full     = r_count == CW'(rqs_pkg::TABLE_DEPTH);
    assign o_stat.empty    = r_count == '0;
    assign o_stat.more     = {1'b0, idx_next} < {1'b0, r_count};
    assign o_stat.id_match = rdata.id == r_item.proc_id;
    assign o_stat.out_free = !r_out_valid || i_ready;

endmodule

`default_nettype wire

// File: rtl/rqs_ctrl.sv
// Controller of the ready queue scheduler: sequences insert, search,
// selection scan and table compaction through datapath commands.
// Depends on rqs_pkg.
`default_nettype none

module rqs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire rqs_pkg::t_dp_stat i_stat,
    output rqs_pkg::t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_INS    = 4'd2;
    localparam logic [3:0] S_SW_RD  = 4'd3;
    localparam logic [3:0] S_SW_CK  = 4'd4;
    localparam logic [3:0] S_SC_RD  = 4'd5;
    localparam logic [3:0] S_SC_E1  = 4'd6;
    localparam logic [3:0] S_SC_E2  = 4'd7;
    localparam logic [3:0] S_SC_X   = 4'd8;
    localparam logic [3:0] S_SC_CMP = 4'd9;
    localparam logic [3:0] S_MV_RD  = 4'd10;
    localparam logic [3:0] S_MV_WR  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= rqs_pkg::ST_OK;
            r_sel    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_sel    <= n_sel;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_status         = r_status;
        n_sel            = r_sel;
        o_ready          = 1'b0;
        o_cmd            = '0;
        o_cmd.res_status = r_status;
        o_cmd.res_sel    = r_sel;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.cap_item = i_valid;
                if (i_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_sel    = 1'b0;
                n_status = rqs_pkg::ST_OK;
                n_state  = S_DONE;
                case (i_stat.func)
                    rqs_pkg::FN_INSERT: begin
                        if (i_stat.full) begin
                            n_status = rqs_pkg::ST_FULL;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                    rqs_pkg::FN_SELECT: begin
                        if (i_stat.empty) begin
                            n_status = rqs_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_SC_RD;
                        end
                    end
                    rqs_pkg::FN_SETWAIT: begin
                        if (i_stat.empty) begin
                            n_status = rqs_pkg::ST_NOTFOUND;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_SW_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = rqs_pkg::WR_INSERT;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DONE;
            end
            S_SW_RD: begin
                o_cmd.ram_re = 1'b1;
                n_state      = S_SW_CK;
            end
            S_SW_CK: begin
                if (i_stat.id_match) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = rqs_pkg::WR_WAIT;
                    n_state      = S_DONE;
                end else if (i_stat.more) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SW_RD;
                end else begin
                    n_status = rqs_pkg::ST_NOTFOUND;
                    n_state  = S_DONE;
                end
            end
            S_SC_RD: begin
                o_cmd.ram_re = 1'b1;
                n_state      = S_SC_E1;
            end
            S_SC_E1: begin
                o_cmd.est1_en = 1'b1;
                n_state       = S_SC_E2;
            end
            S_SC_E2: begin
                o_cmd.est2_en = 1'b1;
                n_state       = S_SC_X;
            end
            S_SC_X: begin
                o_cmd.xp_en = 1'b1;
                n_state     = S_SC_CMP;
            end
            S_SC_CMP: begin
                o_cmd.cmp_en = 1'b1;
                if (i_stat.more) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SC_RD;
                end else begin
                    // restart the index at the chosen slot for compaction
                    o_cmd.idx_best = 1'b1;
                    n_sel          = 1'b1;
                    n_state        = S_MV_RD;
                end
            end
            S_MV_RD: begin
                if (i_stat.more) begin
                    o_cmd.ram_re  = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_MV_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_MV_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = rqs_pkg::WR_MOVE;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_MV_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ready_queue_scheduler_top.sv
// Ready queue scheduler: one item at a time. Insert appends an entry, set
// waiting searches slot by slot, select scans every table entry (one table
// read, two estimate stages, cross products, compare) and then moves the later
// entries down; the table holds up to 16 entries. A result waits in
// an output register while the next item is accepted. Synchronous reset
// empties the table and sets mode FIFO, alpha 128; entry contents stay.
`default_nettype none

module ready_queue_scheduler_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rqs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rqs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire rqs_pkg::t_in_item              i_item,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output rqs_pkg::t_out_item                  o_result
);

    rqs_pkg::t_dp_cmd  cmd;
    rqs_pkg::t_dp_stat stat;

    rqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rqs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .o_result   (o_result),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

`default_nettype wire
